// ----- rtl/core/nsv_pkg.sv -----
// ----------------------------------------------------------------------------
// nsv_pkg
// Shared codes, defaults and the stage-one control word of the sorted-set
// nearest value search.
// ----------------------------------------------------------------------------
package nsv_pkg;

  localparam int CAPACITY_DEFAULT    = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // control handed from the cell row to the pick stage
  typedef struct packed {
    logic       pick;
    logic       lo_any;
    logic       hi_any;
    logic [1:0] status;
  } sel_t;

endpackage

// ----- rtl/core/nearest_value_in_sorted_set.sv -----
// ----------------------------------------------------------------------------
// nearest_value_in_sorted_set
// Sorted set of distinct signed values held in a row of compare cells;
// takes insert, query and clear items and returns one result item each.
// ----------------------------------------------------------------------------
// an accepted item passes the stage-one register, then the output register
// throughput: one item per cycle unless out_ready stalls; all cells compare and
//   an insert shifts the row in the accept cycle, the neighbor choice follows
// reset clears the entry count and both pipeline stages; cell contents are
//   only read below the entry count, so they need no clearing
module nearest_value_in_sorted_set #(
  parameter int CAPACITY    = nsv_pkg::CAPACITY_DEFAULT,
  parameter int VALUE_WIDTH = nsv_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [VALUE_WIDTH-1:0]        value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [VALUE_WIDTH-1:0]        nearest,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]          held_count;
  logic [CW-1:0]          count_next;
  logic                   in_fire;
  logic                   insert_do;
  logic                   dup;
  logic                   full;

  logic [CAPACITY-1:0]    occupied;
  logic [CAPACITY-1:0]    lt;
  logic [CAPACITY-1:0]    eq;
  logic [CAPACITY-1:0]    lo_sel;
  logic [CAPACITY-1:0]    hi_sel;
  logic [VALUE_WIDTH-1:0] vals [CAPACITY];
  logic [VALUE_WIDTH-1:0] lo_val;
  logic [VALUE_WIDTH-1:0] hi_val;

  nsv_pkg::sel_t          sel_next;
  logic                   s1_valid;
  logic                   s1_ready;
  nsv_pkg::sel_t          s1_sel;
  logic [VALUE_WIDTH-1:0] s1_key;
  logic [VALUE_WIDTH-1:0] s1_lo;
  logic [VALUE_WIDTH-1:0] s1_hi;
  logic [CW-1:0]          s1_count;

  assign in_ready = !s1_valid || s1_ready;
  assign in_fire  = in_valid && in_ready;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occupied[i] = CW'(i) < held_count;

    if (i == 0) begin : g_first
      nsv_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
        .clk        (clk),
        .shift_en   (insert_do),
        .occupied   (occupied[i]),
        .after_left (1'b0),
        .left_value (value),
        .value      (value),
        .cell_value (vals[i]),
        .lt         (lt[i]),
        .eq         (eq[i])
      );
      assign hi_sel[i] = occupied[i] && !lt[i];
    end else begin : g_rest
      nsv_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
        .clk        (clk),
        .shift_en   (insert_do),
        .occupied   (occupied[i]),
        .after_left (!lt[i-1]),
        .left_value (vals[i-1]),
        .value      (value),
        .cell_value (vals[i]),
        .lt         (lt[i]),
        .eq         (eq[i])
      );
      assign hi_sel[i] = occupied[i] && !lt[i] && lt[i-1];
    end

    // last cell below the border
    if (i == CAPACITY - 1) begin : g_last
      assign lo_sel[i] = lt[i];
    end else begin : g_mid
      assign lo_sel[i] = lt[i] && !lt[i+1];
    end
  end

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      lo_val = lo_val | ({VALUE_WIDTH{lo_sel[i]}} & vals[i]);
      hi_val = hi_val | ({VALUE_WIDTH{hi_sel[i]}} & vals[i]);
    end
  end

  assign dup  = |eq;
  assign full = held_count == CW'(CAPACITY);

  always_comb begin
    insert_do       = 1'b0;
    count_next      = held_count;
    sel_next.pick   = 1'b0;
    sel_next.lo_any = |lo_sel;
    sel_next.hi_any = |hi_sel;
    sel_next.status = nsv_pkg::ST_OK;
    unique case (operation)
      nsv_pkg::OP_INSERT: begin
        if (dup) begin
          sel_next.status = nsv_pkg::ST_DUP;
        end else if (full) begin
          sel_next.status = nsv_pkg::ST_FULL;
        end else begin
          insert_do  = in_fire;
          count_next = held_count + CW'(1);
        end
      end
      nsv_pkg::OP_QUERY: begin
        if (held_count == '0) begin
          sel_next.status = nsv_pkg::ST_EMPTY;
        end else begin
          sel_next.pick = 1'b1;
        end
      end
      nsv_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (in_fire) begin
        held_count <= count_next;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
    end
    if (in_fire) begin
      s1_sel   <= sel_next;
      s1_key   <= value;
      s1_lo    <= lo_val;
      s1_hi    <= hi_val;
      s1_count <= count_next;
    end
  end

  nsv_pick #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .CAPACITY    (CAPACITY)
  ) u_pick (
    .clk         (clk),
    .rst         (rst),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_sel      (s1_sel),
    .s1_key      (s1_key),
    .s1_lo       (s1_lo),
    .s1_hi       (s1_hi),
    .s1_count    (s1_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .nearest     (nearest),
    .entry_count (entry_count)
  );

endmodule

// ----- rtl/core/nsv_cell.sv -----
// ----------------------------------------------------------------------------
// nsv_cell
// One slot of the sorted row: holds a value, compares it with the item's
// value and takes its left neighbor's value when an insert opens a gap.
// ----------------------------------------------------------------------------
module nsv_cell #(
  parameter int VALUE_WIDTH = nsv_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic                   occupied,
  input  logic                   after_left,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic [VALUE_WIDTH-1:0] cell_value,
  output logic                   lt,
  output logic                   eq
);

  assign lt = occupied && ($signed(cell_value) < $signed(value));
  assign eq = occupied && (cell_value == value);

  // cells at or past the insert point move right; the first one takes the new value
  always_ff @(posedge clk) begin
    if (shift_en && !lt) begin
      cell_value <= after_left ? left_value : value;
    end
  end

endmodule

// ----- rtl/core/nsv_pick.sv -----
// ----------------------------------------------------------------------------
// nsv_pick
// Chooses between the two neighbors of the border by exact distance and
// holds the result item in the output register.
// ----------------------------------------------------------------------------
module nsv_pick #(
  parameter int VALUE_WIDTH = nsv_pkg::VALUE_WIDTH_DEFAULT,
  parameter int CAPACITY    = nsv_pkg::CAPACITY_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s1_valid,
  output logic                          s1_ready,
  input  nsv_pkg::sel_t                 s1_sel,
  input  logic [VALUE_WIDTH-1:0]        s1_key,
  input  logic [VALUE_WIDTH-1:0]        s1_lo,
  input  logic [VALUE_WIDTH-1:0]        s1_hi,
  input  logic [$clog2(CAPACITY+1)-1:0] s1_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [VALUE_WIDTH-1:0]        nearest,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count
);

  logic [VALUE_WIDTH:0]   d_lo;
  logic [VALUE_WIDTH:0]   d_hi;
  logic                   choose_lo;
  logic [VALUE_WIDTH-1:0] nearest_next;

  // distances at one extra bit, both non-negative by construction
  assign d_lo = {s1_key[VALUE_WIDTH-1], s1_key} - {s1_lo[VALUE_WIDTH-1], s1_lo};
  assign d_hi = {s1_hi[VALUE_WIDTH-1], s1_hi} - {s1_key[VALUE_WIDTH-1], s1_key};

  // tie goes to the smaller neighbor
  assign choose_lo    = !s1_sel.hi_any || (s1_sel.lo_any && (d_lo <= d_hi));
  assign nearest_next = !s1_sel.pick ? '0 : (choose_lo ? s1_lo : s1_hi);

  assign s1_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
    if (s1_ready && s1_valid) begin
      status      <= s1_sel.status;
      nearest     <= nearest_next;
      entry_count <= s1_count;
    end
  end

endmodule
